// ===== hw/rtl/swmf_pkg.sv =====
package swmf_pkg;

    localparam int PIX_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int WIDTH_REG_W    = 13;
    localparam int HEIGHT_REG_W   = 16;
    localparam int RAD_W          = 2;
    localparam int OUT_COL_W      = 12;
    localparam int OUT_ROW_W      = 16;
    localparam int COL_W          = 15;
    localparam int ROW_W          = 17;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_RADIUS = 3;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;
    localparam logic [RAD_W-1:0]        RADIUS_RESET = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    typedef logic signed [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic clear;
        logic insert;
    } t_sort_ctl;

endpackage

// ===== hw/rtl/swmf_ifs.sv =====
interface swmf_pix_if;
    import swmf_pkg::*;
    logic valid;
    logic ready;
    t_pix pixel_value;
    logic frame_start;
    modport source(output valid, output pixel_value, output frame_start, input ready);
    modport sink(input valid, input pixel_value, input frame_start, output ready);
endinterface

interface swmf_res_if;
    import swmf_pkg::*;
    logic                 valid;
    logic                 ready;
    t_pix                 filtered_value;
    logic [OUT_COL_W-1:0] out_column;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 run_last;
    modport source(output valid, output filtered_value, output out_column, output out_row,
                   output run_last, input ready);
    modport sink(input valid, input filtered_value, input out_column, input out_row,
                 input run_last, output ready);
endinterface

interface swmf_cfg_if;
    import swmf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/square_window_median_filter.sv =====
// Square-window median filter over a raster stream of signed 32-bit pixels.
// i_pix carries one pixel per beat with a frame_start flag that restarts the
// position at column 0, row 0. o_res carries result beats: the filtered value,
// its column and row, and run_last on the final result caused by one pixel.
// i_cfg writes image width, image height and window radius (indexes 0, 1, 2)
// and is always ready; write it only while the block is idle.
// An input beat is written to the line store when it is taken. For each result
// it causes, the window is then read from the single read port of the line
// store one word per cycle and inserted into a sorting array; a border pixel
// reads only its own stored word.
// No new pixel is taken until all results of the previous one are in the
// output register. The output register holds one result; a stalled receiver
// holds the block in its final step until that register is free.
// Reset restores the register defaults and position zero; the line store is
// not cleared and is only read where the stream has written it.
module square_window_median_filter #(
    parameter int MAX_WIDTH  = swmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = swmf_pkg::DEF_MAX_RADIUS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    swmf_pix_if.sink  i_pix,
    swmf_res_if.source o_res,
    swmf_cfg_if.sink  i_cfg
);
    import swmf_pkg::*;

    localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
    localparam int NCELL      = STORE_ROWS * STORE_ROWS;
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int CIW        = $clog2(MAX_WIDTH);
    localparam int SW         = $clog2(STORE_ROWS);
    localparam int IW         = $clog2(NCELL);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [RAD_W-1:0]        r_rad;

    logic [2:0]       r_state;
    logic [COL_W-1:0] r_colp;
    logic [ROW_W-1:0] r_rowp;
    logic [SW-1:0]    r_slotp;
    logic [ROW_W-1:0] r_y;
    logic [SW-1:0]    r_ys;
    logic [ROW_W-1:0] r_r, r_rhi;
    logic [COL_W-1:0] r_c, r_clo, r_chi;
    logic [SW-1:0]    r_dr, r_dc, r_lastd;
    logic [RAD_W-1:0] r_off;
    logic [IW-1:0]    r_mid;
    logic             r_rd_vld;

    logic                 r_ov;
    t_pix                 r_ofv;
    logic [OUT_COL_W-1:0] r_ocol;
    logic [OUT_ROW_W-1:0] r_orow;
    logic                 r_olast;

    logic [COL_W-1:0] wc, wm1, x, clo, chi, cc;
    logic [ROW_W-1:0] hc, hm1, y, rlo, rhi, rr;
    logic [RAD_W-1:0] radc;
    logic [SW-1:0]    ys, d_s, rslot;
    logic             acc, pos_rst, rows_ok, cols_ok, border, done, load;
    logic [5:0]       mid_full;
    logic [AW-1:0]    waddr, raddr;
    t_pix             rdata, median;
    t_sort_ctl        sort_ctl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_rad    <= RADIUS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:   r_width  <= i_cfg.data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT:  r_height <= i_cfg.data[HEIGHT_REG_W-1:0];
                REG_WINDOW_RADIUS: r_rad    <= i_cfg.data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            wc = COL_W'(1);
        end else if (COL_W'(r_width) > COL_W'(MAX_WIDTH)) begin
            wc = COL_W'(MAX_WIDTH);
        end else begin
            wc = COL_W'(r_width);
        end
        hc = (r_height == '0) ? ROW_W'(1) : ROW_W'(r_height);
        if (r_rad == '0) begin
            radc = RAD_W'(1);
        end else if (r_rad > RAD_W'(MAX_RADIUS)) begin
            radc = RAD_W'(MAX_RADIUS);
        end else begin
            radc = r_rad;
        end
    end

    assign wm1 = wc - COL_W'(1);
    assign hm1 = hc - ROW_W'(1);

    assign i_pix.ready = (r_state == S_IDLE);
    assign acc         = i_pix.valid && i_pix.ready;

    assign pos_rst = i_pix.frame_start || (r_colp >= wc) || (r_rowp >= hc);
    assign x       = pos_rst ? '0 : r_colp;
    assign y       = pos_rst ? '0 : r_rowp;
    assign ys      = pos_rst ? '0 : r_slotp;

    always_comb begin
        if (y < hm1) begin
            rows_ok = (y >= ROW_W'(radc));
            rlo     = y - ROW_W'(radc);
            rhi     = rlo;
        end else begin
            rows_ok = 1'b1;
            rlo     = (hm1 >= ROW_W'(radc)) ? hm1 - ROW_W'(radc) : '0;
            rhi     = hm1;
        end
        if (x < wm1) begin
            cols_ok = (x >= COL_W'(radc));
            clo     = x - COL_W'(radc);
            chi     = clo;
        end else begin
            cols_ok = 1'b1;
            clo     = (wm1 >= COL_W'(radc)) ? wm1 - COL_W'(radc) : '0;
            chi     = wm1;
        end
    end

    assign border = (r_r < ROW_W'(radc)) || (r_c < COL_W'(radc))
                 || (r_r + ROW_W'(radc) > hm1) || (r_c + COL_W'(radc) > wm1);
    assign mid_full = 6'({radc, 1'b0}) * 6'({1'b0, radc} + 3'd1);

    assign rr    = r_r - ROW_W'(r_off) + ROW_W'(r_dr);
    assign cc    = r_c - COL_W'(r_off) + COL_W'(r_dc);
    assign d_s   = SW'(r_y - rr);
    assign rslot = (r_ys >= d_s) ? r_ys - d_s : r_ys + SW'(STORE_ROWS) - d_s;
    assign raddr = AW'(rslot) * AW'(MAX_WIDTH) + AW'(cc[CIW-1:0]);
    assign waddr = AW'(ys) * AW'(MAX_WIDTH) + AW'(x[CIW-1:0]);

    assign done = (r_r == r_rhi) && (r_c == r_chi);
    assign load = (r_state == S_EMIT) && (!r_ov || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_colp   <= '0;
            r_rowp   <= '0;
            r_slotp  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_READ);
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_y   <= y;
                        r_ys  <= ys;
                        r_r   <= rlo;
                        r_rhi <= rhi;
                        r_c   <= clo;
                        r_clo <= clo;
                        r_chi <= chi;
                        if (x + COL_W'(1) >= wc) begin
                            r_colp <= '0;
                            if (y + ROW_W'(1) >= hc) begin
                                r_rowp  <= '0;
                                r_slotp <= '0;
                            end else begin
                                r_rowp  <= y + ROW_W'(1);
                                r_slotp <= (ys == SW'(STORE_ROWS - 1)) ? '0 : ys + SW'(1);
                            end
                        end else begin
                            r_colp  <= x + COL_W'(1);
                            r_rowp  <= y;
                            r_slotp <= ys;
                        end
                        if (rows_ok && cols_ok) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_dr    <= '0;
                    r_dc    <= '0;
                    r_off   <= border ? '0 : radc;
                    r_lastd <= border ? '0 : SW'({radc, 1'b0});
                    r_mid   <= border ? '0 : IW'(mid_full);
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_dc == r_lastd) begin
                        r_dc <= '0;
                        r_dr <= r_dr + SW'(1);
                        if (r_dr == r_lastd) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_dc <= r_dc + SW'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        if (done) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SETUP;
                            if (r_c == r_chi) begin
                                r_c <= r_clo;
                                r_r <= r_r + ROW_W'(1);
                            end else begin
                                r_c <= r_c + COL_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ofv   <= median;
            r_ocol  <= r_c[OUT_COL_W-1:0];
            r_orow  <= r_r[OUT_ROW_W-1:0];
            r_olast <= done;
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.filtered_value = r_ofv;
    assign o_res.out_column     = r_ocol;
    assign o_res.out_row        = r_orow;
    assign o_res.run_last       = r_olast;

    assign sort_ctl.clear  = (r_state == S_SETUP);
    assign sort_ctl.insert = r_rd_vld;

    swmf_line_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (acc),
        .i_waddr(waddr),
        .i_wdata(i_pix.pixel_value),
        .i_re   (r_state == S_READ),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    swmf_rank_sorter #(
        .NCELL(NCELL),
        .IW   (IW)
    ) u_sorter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (sort_ctl),
        .i_data (rdata),
        .i_sel  (r_mid),
        .o_value(median)
    );

    a_read_data_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_READ || r_state == S_DRAIN))
        else $error("read data returned outside a window read");

    a_stall_holds_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ov && !o_res.ready) |=> (r_state == S_EMIT && r_ov))
        else $error("result left the emit step while the output register was full");

    a_drain_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_EMIT && !r_rd_vld))
        else $error("window drain did not lead to emit");

    a_counter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_dr <= r_lastd && r_dc <= r_lastd))
        else $error("window counter ran past the window edge");

endmodule

// ===== hw/rtl/swmf_line_store.sv =====
module swmf_line_store #(
    parameter int DEPTH = 7 * swmf_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  swmf_pkg::t_pix i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output swmf_pkg::t_pix o_rdata
);
    import swmf_pkg::*;

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/swmf_rank_sorter.sv =====
module swmf_rank_sorter #(
    parameter int NCELL = 49,
    parameter int IW    = $clog2(NCELL)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swmf_pkg::t_sort_ctl i_ctl,
    input  swmf_pkg::t_pix     i_data,
    input  logic [IW-1:0]      i_sel,
    output swmf_pkg::t_pix     o_value
);
    import swmf_pkg::*;

    t_pix             r_cell [NCELL];
    logic [NCELL-1:0] r_vld;
    logic [NCELL-1:0] gt;

    // Empty cells count as larger than any sample, so the array stays sorted ascending.
    always_comb begin
        for (int i = 0; i < NCELL; i++) begin
            gt[i] = !r_vld[i] || (r_cell[i] > i_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.insert) begin
            r_vld <= {r_vld[NCELL-2:0], 1'b1};
        end
    end

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_ctl.insert && gt[0]) begin
                    r_cell[0] <= i_data;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_ctl.insert && gt[i]) begin
                    r_cell[i] <= gt[i-1] ? r_cell[i-1] : i_data;
                end
            end
        end
    end

    assign o_value = r_cell[i_sel];

endmodule

// ===== test/tb.sv =====
module tb;
    import swmf_pkg::*;

    typedef struct packed {
        t_pix                 value;
        logic [OUT_COL_W-1:0] column;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } t_filtered;

    localparam int STORE_ROWS = 2 * DEF_MAX_RADIUS + 1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swmf_pix_if pix();
    swmf_res_if res();
    swmf_cfg_if cfg();

    square_window_median_filter uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pix(pix),
        .o_res(res),
        .i_cfg(cfg)
    );

    always #10 i_clk = ~i_clk;

    t_pix line_mem [STORE_ROWS * DEF_MAX_WIDTH];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned width_reg = WIDTH_RESET;
    int unsigned height_reg = HEIGHT_RESET;
    int unsigned radius_reg = RADIUS_RESET;

    t_filtered pending_results[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit steady_send = 0;
    bit steady_recv = 0;
    int recv_stall = 0;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_pix stored_pixel(int unsigned r, int unsigned c);
        return line_mem[(r % STORE_ROWS) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH)];
    endfunction

    function automatic t_pix window_median(int unsigned r, int unsigned c, int unsigned rad);
        t_pix cells[49];
        t_pix v;
        int n;
        int i;
        n = 0;
        for (int unsigned rr = r - rad; rr <= r + rad; rr++) begin
            for (int unsigned cc = c - rad; cc <= c + rad; cc++) begin
                v = stored_pixel(rr, cc);
                i = n;
                while (i > 0 && cells[i - 1] > v) begin
                    cells[i] = cells[i - 1];
                    i--;
                end
                cells[i] = v;
                n++;
            end
        end
        return cells[n / 2];
    endfunction

    function automatic void predict_filter(t_pix v, bit fs);
        int unsigned w, h, rad, x, y, rlo, rhi, clo, chi;
        bit rows_ok, cols_ok, border;
        t_filtered e;
        w = width_reg;
        h = height_reg;
        rad = radius_reg;
        rows_ok = 1;
        cols_ok = 1;
        if (w < 1) w = 1;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        if (h < 1) h = 1;
        if (rad < 1) rad = 1;
        if (rad > DEF_MAX_RADIUS) rad = DEF_MAX_RADIUS;
        if (fs || col_pos >= w || row_pos >= h) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        line_mem[(y % STORE_ROWS) * DEF_MAX_WIDTH + x] = v;
        if (y < h - 1) begin
            if (y >= rad) begin
                rlo = y - rad;
                rhi = rlo;
            end else begin
                rows_ok = 0;
                rlo = 0;
                rhi = 0;
            end
        end else begin
            rlo = (h - 1 >= rad) ? h - 1 - rad : 0;
            rhi = h - 1;
        end
        if (x < w - 1) begin
            if (x >= rad) begin
                clo = x - rad;
                chi = clo;
            end else begin
                cols_ok = 0;
                clo = 0;
                chi = 0;
            end
        end else begin
            clo = (w - 1 >= rad) ? w - 1 - rad : 0;
            chi = w - 1;
        end
        if (rows_ok && cols_ok) begin
            for (int unsigned r = rlo; r <= rhi; r++) begin
                for (int unsigned c = clo; c <= chi; c++) begin
                    border = r < rad || c < rad || r + rad > h - 1 || c + rad > w - 1;
                    e.value = border ? stored_pixel(r, c) : window_median(r, c, rad);
                    e.column = c[OUT_COL_W-1:0];
                    e.row = r[OUT_ROW_W-1:0];
                    e.last = (r == rhi && c == chi);
                    pending_results.push_back(e);
                end
            end
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
    endfunction

    task automatic send_pixel(t_pix v, bit fs);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_value <= v;
        pix.frame_start <= fs;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        predict_filter(v, fs);
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH: width_reg = data & 16'h1FFF;
            REG_IMAGE_HEIGHT: height_reg = data;
            REG_WINDOW_RADIUS: radius_reg = data & 16'h3;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, int rad);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(REG_WINDOW_RADIUS, rad[CFG_DATA_W-1:0]);
        cfg.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 6; i++) begin
            send_pixel($urandom, i == 0);
        end
    endtask

    task automatic test_extreme_values();
        t_pix vals[5] = '{32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 32'sd0, 32'sd1};
        set_geometry(5, 5, 1);
        for (int i = 0; i < 25; i++) begin
            send_pixel(vals[(i * 3) % 5], i == 0);
        end
    endtask

    task automatic test_clamped_registers();
        set_geometry(0, 0, 0);
        for (int i = 0; i < 3; i++) begin
            send_pixel($urandom, 0);
        end
        set_geometry(16'hFFFF, 1, 3);
        for (int i = 0; i < 12; i++) begin
            send_pixel($urandom, i == 0);
        end
    endtask

    task automatic test_narrow_image();
        set_geometry(6, 2, 3);
        for (int i = 0; i < 12; i++) begin
            send_pixel($urandom, i == 0);
        end
        set_geometry(4, 65535, 2);
        for (int i = 0; i < 7; i++) begin
            send_pixel($urandom, i == 0);
        end
        // The stored position now lies past the new width, so the stream restarts.
        set_geometry(2, 3, 1);
        for (int i = 0; i < 6; i++) begin
            send_pixel($urandom, 0);
        end
    endtask

    task automatic test_random_frames();
        int sent;
        int w, h, rad, npix;
        bit narrow_range;
        sent = 0;
        while (sent < 100) begin
            rad = $urandom_range(1, 3);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(2 * rad + 1, 9);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(2 * rad + 1, 8);
            set_geometry(w | ($urandom_range(0, 7) << 13), h, rad | ($urandom_range(0, 3) << 2));
            steady_send = ($urandom_range(0, 3) == 0);
            steady_recv = ($urandom_range(0, 3) == 0);
            narrow_range = $urandom_range(0, 1);
            npix = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h) : w * h;
            for (int i = 0; i < npix; i++) begin
                send_pixel(narrow_range ? $urandom_range(0, 6) - 3 : $urandom,
                           i == 0 || $urandom_range(0, 99) == 0);
                if (i == npix / 2 && sent < 40) begin
                    wait_drained();
                end
            end
            sent += npix;
        end
        steady_send = 0;
        steady_recv = 0;
    endtask

    always @(posedge i_clk) begin
        t_filtered e;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result beat at column %0d row %0d",
                           res.out_column, res.out_row);
                    mismatches++;
                end else begin
                    e = pending_results.pop_front();
                    if (res.filtered_value !== e.value) begin
                        $error("filtered_value expected %0d got %0d", e.value, res.filtered_value);
                        mismatches++;
                    end
                    if (res.out_column !== e.column) begin
                        $error("out_column expected %0d got %0d", e.column, res.out_column);
                        mismatches++;
                    end
                    if (res.out_row !== e.row) begin
                        $error("out_row expected %0d got %0d", e.row, res.out_row);
                        mismatches++;
                    end
                    if (res.run_last !== e.last) begin
                        $error("run_last expected %0d got %0d", e.last, res.run_last);
                        mismatches++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                res.ready <= 1'b0;
            end else if (!steady_recv && $urandom_range(0, 99) < 30) begin
                recv_stall = pick_gap();
                res.ready <= (recv_stall == 0);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pix.valid = 1'b0;
        pix.pixel_value = '0;
        pix.frame_start = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_IMAGE_WIDTH;
        cfg.data = '0;
        res.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extreme_values();
        test_clamped_registers();
        test_narrow_image();
        test_random_frames();
        wait_drained();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
